/* src/ssu_pkg.sv */
package ssu_pkg;

    localparam int DEPTH   = 16;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int VALUE_W = 32;
    localparam int REQ_W   = 2;

    localparam logic [REQ_W-1:0] REQ_LOAD_A = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOAD_B = 2'd1;
    localparam logic [REQ_W-1:0] REQ_MERGE  = 2'd2;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

endpackage

/* src/ssu_ram.sv */
module ssu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* src/sorted_set_union_merge.sv */
// Sorted set union merge. Load transactions (tuser = load A / load B) append
// the signed 32-bit tdata to list A or B, up to DEPTH entries each; loads
// into a full list are dropped. A merge transaction walks both lists from
// their heads with shared signed comparators and emits the ascending union,
// one output transaction per element: equal heads give one copy and both
// lists advance, and once a list runs out the rest of the other is copied.
// tlast marks the final element; an empty merge gives a single transaction
// with tdata 0, tlast 1 and tuser 1. The merge clears both lists. Each
// merged element takes two steps (a registered RAM read of both heads, then
// compare and load into the output register) and waits while the output
// stalls; s_axis_tready is low while a merge runs. Unused request code 3 is
// accepted and ignored.
module sorted_set_union_merge
    import ssu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [VALUE_W-1:0] s_axis_tdata,   // [31:0] value
    input  logic [REQ_W-1:0]   s_axis_tuser,   // [1:0] req_type

    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [VALUE_W-1:0] m_axis_tdata,   // [31:0] result_value
    output logic               m_axis_tlast,   // last
    output logic [0:0]         m_axis_tuser    // [0] empty_res
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_FETCH = 3'b010,
        ST_EMIT  = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_a_reg, count_a_next;
    logic [CNT_W-1:0]   count_b_reg, count_b_next;
    logic [CNT_W-1:0]   i_reg, i_next;
    logic [CNT_W-1:0]   j_reg, j_next;

    logic               out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0] out_data_reg, out_data_next;
    logic               out_last_reg, out_last_next;
    logic               out_empty_reg, out_empty_next;

    logic               out_free;
    logic               in_fire;
    logic               we_a, we_b;
    logic [VALUE_W-1:0] rd_a, rd_b;

    // shared compare unit
    logic               a_done, b_done, a_lt_b, b_lt_a;
    logic               take_a, take_b;
    logic [CNT_W-1:0]   i_adv, j_adv;
    logic               emit_last;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && out_free;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign we_a = in_fire && (s_axis_tuser == REQ_LOAD_A) && (count_a_reg < DEPTH_CNT);
    assign we_b = in_fire && (s_axis_tuser == REQ_LOAD_B) && (count_b_reg < DEPTH_CNT);

    ssu_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_list_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (count_a_reg[IDX_W-1:0]),
        .wdata (s_axis_tdata),
        .raddr (i_reg[IDX_W-1:0]),
        .rdata (rd_a)
    );

    ssu_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_list_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (count_b_reg[IDX_W-1:0]),
        .wdata (s_axis_tdata),
        .raddr (j_reg[IDX_W-1:0]),
        .rdata (rd_b)
    );

    // Head compare; an exhausted list always loses, ties take both.
    always_comb
    begin
        a_done    = (i_reg >= count_a_reg);
        b_done    = (j_reg >= count_b_reg);
        a_lt_b    = $signed(rd_a) < $signed(rd_b);
        b_lt_a    = $signed(rd_b) < $signed(rd_a);
        take_a    = !a_done && (b_done || !b_lt_a);
        take_b    = !b_done && (a_done || !a_lt_b);
        i_adv     = take_a ? i_reg + 1'b1 : i_reg;
        j_adv     = take_b ? j_reg + 1'b1 : j_reg;
        emit_last = (i_adv >= count_a_reg) && (j_adv >= count_b_reg);
    end

    always_comb
    begin
        state_next     = state_reg;
        count_a_next   = count_a_reg;
        count_b_next   = count_b_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_empty_next = out_empty_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (we_a)
                begin
                    count_a_next = count_a_reg + 1'b1;
                end
                if (we_b)
                begin
                    count_b_next = count_b_reg + 1'b1;
                end
                if (in_fire && (s_axis_tuser == REQ_MERGE))
                begin
                    if ((count_a_reg == '0) && (count_b_reg == '0))
                    begin
                        out_valid_next = 1'b1;
                        out_data_next  = '0;
                        out_last_next  = 1'b1;
                        out_empty_next = 1'b1;
                    end
                    else
                    begin
                        i_next     = '0;
                        j_next     = '0;
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FETCH:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = take_a ? rd_a : rd_b;
                    out_last_next  = emit_last;
                    out_empty_next = 1'b0;
                    i_next         = i_adv;
                    j_next         = j_adv;
                    if (emit_last)
                    begin
                        count_a_next = '0;
                        count_b_next = '0;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_a_reg   <= '0;
            count_b_reg   <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_a_reg   <= count_a_next;
            count_b_reg   <= count_b_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        out_last_reg  <= out_last_next;
        out_empty_reg <= out_empty_next;
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_data_reg;
    assign m_axis_tlast    = out_last_reg;
    assign m_axis_tuser[0] = out_empty_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (count_a_reg <= DEPTH_CNT) && (count_b_reg <= DEPTH_CNT))
        else $error("list count above depth");

    a_emit_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> ((i_reg < count_a_reg) || (j_reg < count_b_reg)))
        else $error("emit with both lists exhausted");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_EMIT) && out_free && emit_last)
            |=> ((count_a_reg == '0) && (count_b_reg == '0) && out_valid_reg
                 && out_last_reg))
        else $error("final merge element did not clear lists");

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_empty_reg) |-> out_last_reg)
        else $error("empty flag without last");
`endif

endmodule

/* dv/ssu_union_checker.sv */
`timescale 1ns / 100ps

module ssu_union_checker
    import ssu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               s_axis_tvalid,
    input  logic               s_axis_tready,
    input  logic [VALUE_W-1:0] s_axis_tdata,
    input  logic [REQ_W-1:0]   s_axis_tuser,

    input  logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    input  logic [VALUE_W-1:0] m_axis_tdata,
    input  logic               m_axis_tlast,
    input  logic [0:0]         m_axis_tuser,

    output int                 mismatch_count,
    output int                 outstanding
);

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               is_last;
        logic               is_empty;
    } union_elem_t;

    logic signed [VALUE_W-1:0] set_a [DEPTH];
    logic signed [VALUE_W-1:0] set_b [DEPTH];
    int unsigned               len_a;
    int unsigned               len_b;
    union_elem_t               expected_union [$];

    task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                   input logic [VALUE_W-1:0] want);
        $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Head-compare walk over both sets; equal heads give one copy.
    function automatic void predict_union();
        int unsigned        i;
        int unsigned        j;
        logic [VALUE_W-1:0] v;
        union_elem_t        e;
        i = 0;
        j = 0;
        if (len_a == 0 && len_b == 0) begin
            e = '{value: '0, is_last: 1'b1, is_empty: 1'b1};
            expected_union.push_back(e);
        end
        while (i < len_a || j < len_b) begin
            if (i >= len_a) begin
                v = set_b[j];
                j++;
            end else if (j >= len_b) begin
                v = set_a[i];
                i++;
            end else if (set_a[i] < set_b[j]) begin
                v = set_a[i];
                i++;
            end else if (set_b[j] < set_a[i]) begin
                v = set_b[j];
                j++;
            end else begin
                v = set_a[i];
                i++;
                j++;
            end
            e = '{value: v, is_last: (i >= len_a && j >= len_b), is_empty: 1'b0};
            expected_union.push_back(e);
        end
        len_a = 0;
        len_b = 0;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        union_elem_t e;
        if (!rst_n) begin
            len_a = 0;
            len_b = 0;
            expected_union.delete();
            mismatch_count = 0;
            outstanding <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_union.size() == 0) begin
                    report_mismatch("unexpected result", m_axis_tdata, 'x);
                end else begin
                    e = expected_union.pop_front();
                    if (m_axis_tdata !== e.value)
                        report_mismatch("result value", m_axis_tdata, e.value);
                    if (m_axis_tlast !== e.is_last)
                        report_mismatch("last flag", VALUE_W'(m_axis_tlast),
                                        VALUE_W'(e.is_last));
                    if (m_axis_tuser[0] !== e.is_empty)
                        report_mismatch("empty flag", VALUE_W'(m_axis_tuser[0]),
                                        VALUE_W'(e.is_empty));
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                case (s_axis_tuser)
                    REQ_LOAD_A: begin
                        if (len_a < DEPTH) begin
                            set_a[len_a] = s_axis_tdata;
                            len_a++;
                        end
                    end
                    REQ_LOAD_B: begin
                        if (len_b < DEPTH) begin
                            set_b[len_b] = s_axis_tdata;
                            len_b++;
                        end
                    end
                    REQ_MERGE: predict_union();
                    default: ;
                endcase
            end
            outstanding <= expected_union.size();
        end
    end

endmodule

/* dv/tb_sorted_set_union_merge.sv */
`timescale 1ns / 100ps

// Stimulus side of the union merge bench. Loads fill sets A and B, a merge
// transaction drains them; the checker beside the DUT predicts and compares.
module tb_sorted_set_union_merge;
    import ssu_pkg::*;

    // request code 3 is accepted by the block and does nothing
    localparam logic [REQ_W-1:0] REQ_IGNORED = 2'd3;
    localparam int               IDLE_PCT    = 38;
    localparam int               ITEM_GOAL   = 250;

    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;

    logic               s_axis_tvalid = 1'b0;
    wire                s_axis_tready;
    logic [VALUE_W-1:0] s_axis_tdata  = '0;
    logic [REQ_W-1:0]   s_axis_tuser  = '0;

    wire                m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    wire  [VALUE_W-1:0] m_axis_tdata;
    wire                m_axis_tlast;
    wire  [0:0]         m_axis_tuser;

    int                 mismatch_count;
    int                 outstanding;
    bit                 steady        = 1'b0;   // both sides run flat out while set
    int                 sent_items    = 0;      // loads and merges, not ignored codes

    always #5 clk = ~clk;

    sorted_set_union_merge dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    ssu_union_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tlast   (m_axis_tlast),
        .m_axis_tuser   (m_axis_tuser),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    // Output backpressure: random stalls, none during the steady stretch.
    always @(posedge clk)
        m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);

    // One input transaction. Random idle cycles go in front; tvalid stays high
    // across back-to-back transactions, so it gets one assignment per edge.
    task automatic send_req(input logic [REQ_W-1:0] req, input logic [VALUE_W-1:0] val);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= val;
        s_axis_tuser  <= req;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (req != REQ_IGNORED)
            sent_items++;
    endtask

    // Narrow values collide often (equal heads, in-set duplicates); wide ones
    // toggle every data bit. Both extremes show up now and then.
    function automatic int pick_value(input bit narrow);
        int r;
        r = $urandom_range(19);
        if (r == 0)
            return 32'h8000_0000;
        if (r == 1)
            return 32'h7fff_ffff;
        if (narrow)
            return $urandom_range(16) - 8;
        return int'($urandom);
    endfunction

    // Mostly short sets; sometimes close to or past DEPTH so full-set drops hit.
    function automatic int pick_len();
        if ($urandom_range(9) < 7)
            return $urandom_range(6);
        return $urandom_range(DEPTH + 3, DEPTH - 2);
    endfunction

    // Fill both sets with random interleaving, then merge.
    task automatic load_and_merge(input bit sorted_vals, input bit narrow);
        int vals_a [$];
        int vals_b [$];
        int na;
        int nb;
        na = pick_len();
        nb = pick_len();
        repeat (na) vals_a.push_back(pick_value(narrow));
        repeat (nb) vals_b.push_back(pick_value(narrow));
        if (sorted_vals) begin
            vals_a.sort();
            vals_b.sort();
        end
        while (vals_a.size() > 0 || vals_b.size() > 0) begin
            if (vals_b.size() == 0 || (vals_a.size() > 0 && $urandom_range(1)))
                send_req(REQ_LOAD_A, vals_a.pop_front());
            else
                send_req(REQ_LOAD_B, vals_b.pop_front());
            if ($urandom_range(99) < 4)
                send_req(REQ_IGNORED, $urandom);
        end
        send_req(REQ_MERGE, $urandom);
    endtask

    initial begin
        int seq;
        int r;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // --- directed ---
        // empty merge: single flagged result
        send_req(REQ_MERGE, 32'hffff_ffff);
        // extremes on both sides, equal heads at min, zero and max
        send_req(REQ_LOAD_A, 32'h8000_0000);
        send_req(REQ_LOAD_A, 32'hffff_ffff);
        send_req(REQ_LOAD_A, 32'h0000_0000);
        send_req(REQ_LOAD_A, 32'd5);
        send_req(REQ_LOAD_A, 32'h7fff_ffff);
        send_req(REQ_LOAD_B, 32'h8000_0000);
        send_req(REQ_LOAD_B, 32'h0000_0000);
        send_req(REQ_LOAD_B, 32'd3);
        send_req(REQ_LOAD_B, 32'h7fff_ffff);
        send_req(REQ_MERGE, 32'h0);
        // one set empty, then the other
        send_req(REQ_LOAD_A, 32'd1);
        send_req(REQ_LOAD_A, 32'd2);
        send_req(REQ_LOAD_A, 32'd3);
        send_req(REQ_MERGE, 32'h0);
        send_req(REQ_LOAD_B, 32'hffff_fffe);
        send_req(REQ_LOAD_B, 32'hffff_ffff);
        send_req(REQ_MERGE, 32'h0);
        // ignored code, duplicate inside A meeting one copy in B
        send_req(REQ_IGNORED, 32'hffff_ffff);
        send_req(REQ_LOAD_A, 32'd4);
        send_req(REQ_LOAD_A, 32'd4);
        send_req(REQ_LOAD_B, 32'd4);
        // unsorted B
        send_req(REQ_LOAD_B, 32'd9);
        send_req(REQ_LOAD_B, 32'd1);
        send_req(REQ_MERGE, 32'h0);

        // --- random ---
        seq = 0;
        while (sent_items < ITEM_GOAL) begin
            steady = (seq >= 8 && seq < 14);
            r = $urandom_range(99);
            if (r < 65) begin
                load_and_merge(1'b1, 1'($urandom_range(1)));
            end else if (r < 80) begin
                load_and_merge(1'b0, 1'($urandom_range(1)));
            end else begin
                // noise: any code, any value, merge only sometimes
                repeat ($urandom_range(8, 1))
                    send_req(REQ_W'($urandom_range(3)), $urandom);
                if ($urandom_range(1))
                    send_req(REQ_MERGE, $urandom);
            end
            seq++;
        end
        steady = 1'b0;
        s_axis_tvalid <= 1'b0;

        // drain (outstanding is registered, so it lags the last accept), then a
        // short tail to catch anything extra
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (mismatch_count == 0 && outstanding == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // watchdog: far beyond the slowest correct run
    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
